// ----- hw/rtl/magc_pkg.sv -----
// Shared constants, types and the helper function of the magnetometer compensation pipeline.
package magc_pkg;

    localparam int SAMPLE_WIDTH   = 16;
    localparam int COEF_FRAC_BITS = 14;
    localparam int COEF_WIDTH     = COEF_FRAC_BITS + 2;
    localparam int REG_WIDTH      = 48;
    localparam int NUM_AXES       = 3;

    localparam int DIFF_WIDTH  = SAMPLE_WIDTH + 1;
    localparam int PROD_WIDTH  = COEF_WIDTH + DIFF_WIDTH;
    localparam int ACC_WIDTH   = PROD_WIDTH + 2;
    localparam int RND_WIDTH   = ACC_WIDTH - COEF_FRAC_BITS;
    localparam int SQ_WIDTH    = 2 * SAMPLE_WIDTH;
    localparam int SUMSQ_WIDTH = SQ_WIDTH;
    localparam int ROOT_WIDTH  = SAMPLE_WIDTH;
    localparam int REM_WIDTH   = ROOT_WIDTH + 2;

    localparam int SQRT_STEPS_PER_STAGE = 2;
    localparam int SQRT_STAGES          = ROOT_WIDTH / SQRT_STEPS_PER_STAGE;
    localparam int SQRT_SHIFT           = 2 * SQRT_STEPS_PER_STAGE;

    localparam int STG_DIFF   = 0;
    localparam int STG_PROD   = 1;
    localparam int STG_SAT    = 2;
    localparam int STG_SQ     = 3;
    localparam int STG_SUM    = 4;
    localparam int STG_ROOT0  = 5;
    localparam int NUM_STAGES = STG_ROOT0 + SQRT_STAGES;
    localparam int CARRY_DEPTH = NUM_STAGES - STG_SUM;

    localparam int CFG_INDEX_WIDTH = 3;

    localparam logic [REG_WIDTH-1:0] MATRIX_ROW0_RESET =
        REG_WIDTH'(1) << COEF_FRAC_BITS;
    localparam logic [REG_WIDTH-1:0] MATRIX_ROW1_RESET =
        REG_WIDTH'(1) << (COEF_FRAC_BITS + COEF_WIDTH);
    localparam logic [REG_WIDTH-1:0] MATRIX_ROW2_RESET =
        REG_WIDTH'(1) << (COEF_FRAC_BITS + 2 * COEF_WIDTH);

    localparam logic signed [ACC_WIDTH-1:0] RND_HALF =
        ACC_WIDTH'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_MATRIX_ROW0      = 3'd0,
        CFG_MATRIX_ROW1      = 3'd1,
        CFG_MATRIX_ROW2      = 3'd2,
        CFG_HARD_IRON_OFFSET = 3'd3
    } cfg_index_t;

    typedef struct packed {
        logic prod_en;
        logic sat_en;
        logic sq_en;
    } lane_ctrl_t;

    typedef struct packed {
        logic                   sum_en;
        logic [SQRT_STAGES-1:0] step_en;
    } sqrt_ctrl_t;

    typedef struct packed {
        logic [REM_WIDTH-1:0]  rem;
        logic [ROOT_WIDTH-1:0] root;
    } sqrt_state_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] comp_x;
        logic signed [SAMPLE_WIDTH-1:0] comp_y;
        logic signed [SAMPLE_WIDTH-1:0] comp_z;
        logic                           clipped;
    } result_payload_t;

    // One digit of the restoring square root: brings down two radicand bits.
    function automatic sqrt_state_t sqrt_step(sqrt_state_t cur, logic [1:0] pair);
        logic [REM_WIDTH+1:0] rem_sh;
        logic [REM_WIDTH+1:0] trial;
        sqrt_state_t          nxt;
        rem_sh = {cur.rem, pair};
        trial  = {2'b00, cur.root, 2'b01};
        if (rem_sh >= trial) begin
            nxt.rem  = REM_WIDTH'(rem_sh - trial);
            nxt.root = {cur.root[ROOT_WIDTH-2:0], 1'b1};
        end else begin
            nxt.rem  = rem_sh[REM_WIDTH-1:0];
            nxt.root = {cur.root[ROOT_WIDTH-2:0], 1'b0};
        end
        return nxt;
    endfunction

endpackage

// ----- hw/rtl/magc_lane.sv -----
// One output axis lane: row dot product, rounding, saturation and squaring.
module magc_lane (
    input  logic                                     aclk,
    input  magc_pkg::lane_ctrl_t                     ctrl,
    input  logic [magc_pkg::REG_WIDTH-1:0]           row,
    input  logic signed [magc_pkg::DIFF_WIDTH-1:0]   diff_x,
    input  logic signed [magc_pkg::DIFF_WIDTH-1:0]   diff_y,
    input  logic signed [magc_pkg::DIFF_WIDTH-1:0]   diff_z,
    output logic signed [magc_pkg::SAMPLE_WIDTH-1:0] comp,
    output logic                                     clip,
    output logic [magc_pkg::SQ_WIDTH-1:0]            sq
);

    logic signed [magc_pkg::COEF_WIDTH-1:0] coef [magc_pkg::NUM_AXES];
    logic signed [magc_pkg::DIFF_WIDTH-1:0] diff [magc_pkg::NUM_AXES];
    logic signed [magc_pkg::PROD_WIDTH-1:0] prod_reg [magc_pkg::NUM_AXES];
    logic signed [magc_pkg::PROD_WIDTH-1:0] prod_next [magc_pkg::NUM_AXES];

    logic signed [magc_pkg::ACC_WIDTH-1:0]    acc;
    logic signed [magc_pkg::RND_WIDTH-1:0]    rnd;
    logic [magc_pkg::RND_WIDTH-magc_pkg::SAMPLE_WIDTH:0] rnd_top;
    logic signed [magc_pkg::SAMPLE_WIDTH-1:0] sat_next;
    logic                                     clip_next;
    logic signed [magc_pkg::SAMPLE_WIDTH-1:0] sat_reg;
    logic                                     clip_sat_reg;
    logic [magc_pkg::SAMPLE_WIDTH-1:0]        mag;

    logic signed [magc_pkg::SAMPLE_WIDTH-1:0] comp_reg;
    logic                                     clip_reg;
    logic [magc_pkg::SQ_WIDTH-1:0]            sq_reg;

    always_comb begin
        diff[0] = diff_x;
        diff[1] = diff_y;
        diff[2] = diff_z;
        for (int j = 0; j < magc_pkg::NUM_AXES; j++) begin
            coef[j]      = row[j*magc_pkg::COEF_WIDTH +: magc_pkg::COEF_WIDTH];
            prod_next[j] = magc_pkg::PROD_WIDTH'(coef[j]) * magc_pkg::PROD_WIDTH'(diff[j]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.prod_en) begin
            for (int j = 0; j < magc_pkg::NUM_AXES; j++) begin
                prod_reg[j] <= prod_next[j];
            end
        end
    end

    always_comb begin
        acc = magc_pkg::ACC_WIDTH'(prod_reg[0]) + magc_pkg::ACC_WIDTH'(prod_reg[1])
            + magc_pkg::ACC_WIDTH'(prod_reg[2]) + magc_pkg::RND_HALF;
        rnd     = acc[magc_pkg::ACC_WIDTH-1:magc_pkg::COEF_FRAC_BITS];
        rnd_top = rnd[magc_pkg::RND_WIDTH-1:magc_pkg::SAMPLE_WIDTH-1];
        if ((&rnd_top) || !(|rnd_top)) begin
            sat_next  = rnd[magc_pkg::SAMPLE_WIDTH-1:0];
            clip_next = 1'b0;
        end else begin
            sat_next  = rnd[magc_pkg::RND_WIDTH-1] ? magc_pkg::SAT_MIN : magc_pkg::SAT_MAX;
            clip_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.sat_en) begin
            sat_reg      <= sat_next;
            clip_sat_reg <= clip_next;
        end
    end

    assign mag = sat_reg[magc_pkg::SAMPLE_WIDTH-1] ? magc_pkg::SAMPLE_WIDTH'(-sat_reg)
                                                   : sat_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.sq_en) begin
            comp_reg <= sat_reg;
            clip_reg <= clip_sat_reg;
            sq_reg   <= magc_pkg::SQ_WIDTH'(mag) * magc_pkg::SQ_WIDTH'(mag);
        end
    end

    assign comp = comp_reg;
    assign clip = clip_reg;
    assign sq   = sq_reg;

endmodule

// ----- hw/rtl/magc_isqrt.sv -----
// Merging stage: sum of the lane squares and a pipelined floor square root.
module magc_isqrt (
    input  logic                                aclk,
    input  magc_pkg::sqrt_ctrl_t                ctrl,
    input  logic [magc_pkg::SQ_WIDTH-1:0]       sq_x,
    input  logic [magc_pkg::SQ_WIDTH-1:0]       sq_y,
    input  logic [magc_pkg::SQ_WIDTH-1:0]       sq_z,
    output logic [magc_pkg::ROOT_WIDTH-1:0]     root
);

    logic [magc_pkg::SUMSQ_WIDTH-1:0] sum_reg;
    logic [magc_pkg::SUMSQ_WIDTH-1:0] rad_reg   [magc_pkg::SQRT_STAGES];
    magc_pkg::sqrt_state_t            state_reg [magc_pkg::SQRT_STAGES];

    always_ff @(posedge aclk) begin
        if (ctrl.sum_en) begin
            sum_reg <= sq_x + sq_y + sq_z;
        end
    end

    for (genvar k = 0; k < magc_pkg::SQRT_STAGES; k++) begin : g_step
        logic [magc_pkg::SUMSQ_WIDTH-1:0] rad_in;
        magc_pkg::sqrt_state_t            state_in;
        magc_pkg::sqrt_state_t            state_mid;
        magc_pkg::sqrt_state_t            state_next;

        if (k == 0) begin : g_first
            assign rad_in   = sum_reg;
            assign state_in = '0;
        end else begin : g_rest
            assign rad_in   = rad_reg[k-1];
            assign state_in = state_reg[k-1];
        end

        always_comb begin
            state_mid  = magc_pkg::sqrt_step(state_in,
                rad_in[magc_pkg::SUMSQ_WIDTH-1 -: 2]);
            state_next = magc_pkg::sqrt_step(state_mid,
                rad_in[magc_pkg::SUMSQ_WIDTH-3 -: 2]);
        end

        always_ff @(posedge aclk) begin
            if (ctrl.step_en[k]) begin
                rad_reg[k]   <= rad_in << magc_pkg::SQRT_SHIFT;
                state_reg[k] <= state_next;
            end
        end
    end

    assign root = state_reg[magc_pkg::SQRT_STAGES-1].root;

endmodule

// ----- hw/rtl/magnetometer_affine_compensation.sv -----
// Top level of the magnetometer hard-iron and soft-iron compensation pipeline.
//
// The block takes one raw sample per cycle unless back-pressure from the
// output reaches the first stage. One stage subtracts the hard-iron offset,
// three parallel lanes (one per output axis) form the matrix products, round
// and saturate, and square, a merging stage sums the squares, and eight stages
// of a two-bit-per-stage root extractor give the field magnitude. Every stage
// holds its own valid bit, so a stalled result only stops the stages behind it
// that are full; empty stages keep taking new samples. Configuration registers
// are read live by the pipeline and are to be written only while it is empty.
module magnetometer_affine_compensation (
    input  logic                                       aclk,
    input  logic                                       aresetn,

    input  logic                                       cfg_wr_en,
    input  logic [magc_pkg::CFG_INDEX_WIDTH-1:0]       cfg_index,
    input  logic [magc_pkg::REG_WIDTH-1:0]             cfg_wr_data,

    input  logic                                       s_valid,
    output logic                                       s_ready,
    input  logic signed [magc_pkg::SAMPLE_WIDTH-1:0]   s_raw_x,
    input  logic signed [magc_pkg::SAMPLE_WIDTH-1:0]   s_raw_y,
    input  logic signed [magc_pkg::SAMPLE_WIDTH-1:0]   s_raw_z,

    output logic                                       m_valid,
    input  logic                                       m_ready,
    output logic signed [magc_pkg::SAMPLE_WIDTH-1:0]   m_comp_x,
    output logic signed [magc_pkg::SAMPLE_WIDTH-1:0]   m_comp_y,
    output logic signed [magc_pkg::SAMPLE_WIDTH-1:0]   m_comp_z,
    output logic [magc_pkg::ROOT_WIDTH-1:0]            m_field_magnitude,
    output logic                                       m_clipped
);

    logic [magc_pkg::REG_WIDTH-1:0] matrix_row_reg [magc_pkg::NUM_AXES];
    logic [magc_pkg::REG_WIDTH-1:0] offset_reg;

    logic [magc_pkg::NUM_STAGES-1:0] valid_reg;
    logic [magc_pkg::NUM_STAGES-1:0] valid_next;
    logic [magc_pkg::NUM_STAGES-1:0] stage_ready;
    logic [magc_pkg::NUM_STAGES-1:0] load;

    logic signed [magc_pkg::DIFF_WIDTH-1:0] diff_reg  [magc_pkg::NUM_AXES];
    logic signed [magc_pkg::DIFF_WIDTH-1:0] diff_next [magc_pkg::NUM_AXES];
    logic signed [magc_pkg::SAMPLE_WIDTH-1:0] raw [magc_pkg::NUM_AXES];
    logic signed [magc_pkg::SAMPLE_WIDTH-1:0] offset [magc_pkg::NUM_AXES];

    magc_pkg::lane_ctrl_t lane_ctrl;
    magc_pkg::sqrt_ctrl_t sqrt_ctrl;

    logic signed [magc_pkg::SAMPLE_WIDTH-1:0] lane_comp [magc_pkg::NUM_AXES];
    logic [magc_pkg::NUM_AXES-1:0]            lane_clip;
    logic [magc_pkg::SQ_WIDTH-1:0]            lane_sq   [magc_pkg::NUM_AXES];

    magc_pkg::result_payload_t carry_reg [magc_pkg::CARRY_DEPTH];
    magc_pkg::result_payload_t carry_in;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            matrix_row_reg[0] <= magc_pkg::MATRIX_ROW0_RESET;
            matrix_row_reg[1] <= magc_pkg::MATRIX_ROW1_RESET;
            matrix_row_reg[2] <= magc_pkg::MATRIX_ROW2_RESET;
            offset_reg        <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                magc_pkg::CFG_MATRIX_ROW0:      matrix_row_reg[0] <= cfg_wr_data;
                magc_pkg::CFG_MATRIX_ROW1:      matrix_row_reg[1] <= cfg_wr_data;
                magc_pkg::CFG_MATRIX_ROW2:      matrix_row_reg[2] <= cfg_wr_data;
                magc_pkg::CFG_HARD_IRON_OFFSET: offset_reg        <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Per-stage handshake: a stage moves when it is empty or its successor moves.
    always_comb begin
        stage_ready[magc_pkg::NUM_STAGES-1] = !valid_reg[magc_pkg::NUM_STAGES-1] || m_ready;
        for (int k = magc_pkg::NUM_STAGES - 2; k >= 0; k--) begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
        load[0]       = s_valid && stage_ready[0];
        valid_next[0] = stage_ready[0] ? s_valid : valid_reg[0];
        for (int k = 1; k < magc_pkg::NUM_STAGES; k++) begin
            load[k]       = valid_reg[k-1] && stage_ready[k];
            valid_next[k] = stage_ready[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = stage_ready[magc_pkg::STG_DIFF];

    // Offset subtraction stage.
    always_comb begin
        raw[0] = s_raw_x;
        raw[1] = s_raw_y;
        raw[2] = s_raw_z;
        for (int j = 0; j < magc_pkg::NUM_AXES; j++) begin
            offset[j]    = offset_reg[j*magc_pkg::SAMPLE_WIDTH +: magc_pkg::SAMPLE_WIDTH];
            diff_next[j] = magc_pkg::DIFF_WIDTH'(raw[j]) - magc_pkg::DIFF_WIDTH'(offset[j]);
        end
    end

    always_ff @(posedge aclk) begin
        if (load[magc_pkg::STG_DIFF]) begin
            for (int j = 0; j < magc_pkg::NUM_AXES; j++) begin
                diff_reg[j] <= diff_next[j];
            end
        end
    end

    assign lane_ctrl.prod_en = load[magc_pkg::STG_PROD];
    assign lane_ctrl.sat_en  = load[magc_pkg::STG_SAT];
    assign lane_ctrl.sq_en   = load[magc_pkg::STG_SQ];

    for (genvar i = 0; i < magc_pkg::NUM_AXES; i++) begin : g_lane
        magc_lane u_lane (
            .aclk   (aclk),
            .ctrl   (lane_ctrl),
            .row    (matrix_row_reg[i]),
            .diff_x (diff_reg[0]),
            .diff_y (diff_reg[1]),
            .diff_z (diff_reg[2]),
            .comp   (lane_comp[i]),
            .clip   (lane_clip[i]),
            .sq     (lane_sq[i])
        );
    end

    assign sqrt_ctrl.sum_en  = load[magc_pkg::STG_SUM];
    assign sqrt_ctrl.step_en = load[magc_pkg::NUM_STAGES-1:magc_pkg::STG_ROOT0];

    magc_isqrt u_isqrt (
        .aclk (aclk),
        .ctrl (sqrt_ctrl),
        .sq_x (lane_sq[0]),
        .sq_y (lane_sq[1]),
        .sq_z (lane_sq[2]),
        .root (m_field_magnitude)
    );

    // Axis values and clip flag travel beside the root extractor.
    assign carry_in.comp_x  = lane_comp[0];
    assign carry_in.comp_y  = lane_comp[1];
    assign carry_in.comp_z  = lane_comp[2];
    assign carry_in.clipped = |lane_clip;

    always_ff @(posedge aclk) begin
        if (load[magc_pkg::STG_SUM]) begin
            carry_reg[0] <= carry_in;
        end
        for (int c = 1; c < magc_pkg::CARRY_DEPTH; c++) begin
            if (load[magc_pkg::STG_SUM + c]) begin
                carry_reg[c] <= carry_reg[c-1];
            end
        end
    end

    assign m_valid   = valid_reg[magc_pkg::NUM_STAGES-1];
    assign m_comp_x  = carry_reg[magc_pkg::CARRY_DEPTH-1].comp_x;
    assign m_comp_y  = carry_reg[magc_pkg::CARRY_DEPTH-1].comp_y;
    assign m_comp_z  = carry_reg[magc_pkg::CARRY_DEPTH-1].comp_z;
    assign m_clipped = carry_reg[magc_pkg::CARRY_DEPTH-1].clipped;

    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> valid_reg[magc_pkg::STG_DIFF])
        else $error("Accepted request did not enter the first stage.");

    a_no_item_lost: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_valid && m_ready) |=> $countones(valid_reg) >= $past($countones(valid_reg)))
        else $error("A request vanished from the pipeline without being delivered.");

    a_empty_head_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !valid_reg[magc_pkg::STG_DIFF] |-> s_ready)
        else $error("Input stalled although the first stage is empty.");

    a_zero_magnitude: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_comp_x == '0 && m_comp_y == '0 && m_comp_z == '0
        |-> m_field_magnitude == '0)
        else $error("Nonzero magnitude reported for a zero vector.");

endmodule
